// ===== src/msg_pkg.sv =====
`default_nettype none

package msg_pkg;

    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;

    localparam int unsigned S_TDATA_W = 168;
    localparam int unsigned S_TUSER_W = 5;
    localparam int unsigned M_TDATA_W = 56;

    localparam int unsigned MAG_W = 17;
    localparam int unsigned L1_W  = 19;

    // register index (paddr[4:2])
    typedef enum logic [2:0] {
        REG_STALE_TIMEOUT = 3'd0,
        REG_GYRO_LIMIT    = 3'd1,
        REG_TILT_LIMIT    = 3'd2,
        REG_SHOCK_LIMIT   = 3'd3,
        REG_STEER_LIMIT   = 3'd4
    } reg_idx_t;

    localparam logic [15:0] STALE_TIMEOUT_RST = 16'd200;
    localparam logic [15:0] GYRO_LIMIT_RST    = 16'd3000;
    localparam logic [15:0] TILT_LIMIT_RST    = 16'd700;
    localparam logic [16:0] SHOCK_LIMIT_RST   = 17'd3000;
    localparam logic [14:0] STEER_LIMIT_RST   = 15'd45;

    // sensor_flags bits
    localparam int unsigned FLAG_INIT  = 0;
    localparam int unsigned FLAG_TOF_L = 1;
    localparam int unsigned FLAG_TOF_C = 2;
    localparam int unsigned FLAG_TOF_R = 3;
    localparam int unsigned FLAG_FRESH = 4;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [15:0] steer;
        logic               enable;
        logic               init;
        logic               fresh;
        logic               tof_all;
        logic               in_time;
        logic               forward;
        logic [MAG_W-1:0]   ax;
        logic [MAG_W-1:0]   ay;
        logic [MAG_W-1:0]   az;
        logic [MAG_W-1:0]   gx;
        logic [MAG_W-1:0]   gy;
        logic [MAG_W-1:0]   gz;
    } stg1_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [15:0] steer;
        logic               enable;
        logic               fresh;
        logic               tof;
        logic               hard;
        logic               forward;
        logic               gyro_tilt_ok;
        logic [L1_W-1:0]    l1;
    } stg2_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [15:0] steer;
        logic               enable;
        logic               tof;
        logic               imu;
        logic               allowed;
        logic               hard;
    } stg3_t;

    // exact magnitude, -32768 gives 32768
    function automatic logic [MAG_W-1:0] mag16(input logic signed [15:0] v);
        logic [MAG_W-1:0] ext;
        ext = {v[15], v};
        return v[15] ? (~ext + 17'd1) : ext;
    endfunction

endpackage

`default_nettype wire

// ===== src/motion_safety_gate.sv =====
// throughput: one word per cycle while m_tready does not stall the output;
// three register stages (magnitudes and clamp, l1 sum and limit checks, shock
// check and veto) with valid bits and a ready chain
// reset: rst_n clears all stage valid bits and loads the registers with their
// default limits (timeout 200, gyro 3000, tilt 700, shock 3000, steer 45)
`default_nettype none

module motion_safety_gate (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // apb configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [msg_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [msg_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [msg_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // req_left, req_right, req_steer, req_enable, age_ms, accel_x, accel_y,
    // accel_z, gyro_x, gyro_y, gyro_z, zero pad
    input  wire logic [msg_pkg::S_TDATA_W-1:0]   s_tdata,
    // sensor_flags
    input  wire logic [msg_pkg::S_TUSER_W-1:0]   s_tuser,
    // output stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // out_left, out_right, out_steer, out_enable, ranging ok, imu ok,
    // drive permitted, hard stop, zero pad
    output logic      [msg_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic [15:0] stale_timeout_reg;
    logic [15:0] gyro_limit_reg;
    logic [15:0] tilt_limit_reg;
    logic [16:0] shock_limit_reg;
    logic [14:0] steer_limit_reg;

    msg_pkg::reg_idx_t cfg_idx;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = msg_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_timeout_reg <= msg_pkg::STALE_TIMEOUT_RST;
            gyro_limit_reg    <= msg_pkg::GYRO_LIMIT_RST;
            tilt_limit_reg    <= msg_pkg::TILT_LIMIT_RST;
            shock_limit_reg   <= msg_pkg::SHOCK_LIMIT_RST;
            steer_limit_reg   <= msg_pkg::STEER_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                msg_pkg::REG_STALE_TIMEOUT: stale_timeout_reg <= pwdata[15:0];
                msg_pkg::REG_GYRO_LIMIT:    gyro_limit_reg    <= pwdata[15:0];
                msg_pkg::REG_TILT_LIMIT:    tilt_limit_reg    <= pwdata[15:0];
                msg_pkg::REG_SHOCK_LIMIT:   shock_limit_reg   <= pwdata[16:0];
                msg_pkg::REG_STEER_LIMIT:   steer_limit_reg   <= pwdata[14:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            msg_pkg::REG_STALE_TIMEOUT: prdata = {16'd0, stale_timeout_reg};
            msg_pkg::REG_GYRO_LIMIT:    prdata = {16'd0, gyro_limit_reg};
            msg_pkg::REG_TILT_LIMIT:    prdata = {16'd0, tilt_limit_reg};
            msg_pkg::REG_SHOCK_LIMIT:   prdata = {15'd0, shock_limit_reg};
            msg_pkg::REG_STEER_LIMIT:   prdata = {17'd0, steer_limit_reg};
            default:                    prdata = '0;
        endcase
    end

    // ready chain: a stage loads when it is empty or its contents move on
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3     = !s3_valid_reg || m_tready;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_valid_reg <= s_tvalid;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage 1: unpack, magnitudes, age check, steering clamp
    msg_pkg::stg1_t s1_reg, s1_next;

    logic signed [15:0] in_left, in_right, in_steer;
    logic signed [16:0] steer_ext, lim_pos, lim_neg;

    assign in_left   = s_tdata[15:0];
    assign in_right  = s_tdata[31:16];
    assign in_steer  = s_tdata[47:32];
    assign steer_ext = {in_steer[15], in_steer};
    assign lim_pos   = {2'b00, steer_limit_reg};
    assign lim_neg   = -lim_pos;

    always_comb
    begin
        s1_next.left    = in_left;
        s1_next.right   = in_right;
        s1_next.enable  = s_tdata[48];
        s1_next.init    = s_tuser[msg_pkg::FLAG_INIT];
        s1_next.fresh   = s_tuser[msg_pkg::FLAG_FRESH];
        s1_next.tof_all = s_tuser[msg_pkg::FLAG_TOF_L] && s_tuser[msg_pkg::FLAG_TOF_C]
                          && s_tuser[msg_pkg::FLAG_TOF_R];
        s1_next.in_time = s_tdata[64:49] <= stale_timeout_reg;
        s1_next.forward = (in_left > 16'sd0) || (in_right > 16'sd0);
        s1_next.ax      = msg_pkg::mag16(s_tdata[80:65]);
        s1_next.ay      = msg_pkg::mag16(s_tdata[96:81]);
        s1_next.az      = msg_pkg::mag16(s_tdata[112:97]);
        s1_next.gx      = msg_pkg::mag16(s_tdata[128:113]);
        s1_next.gy      = msg_pkg::mag16(s_tdata[144:129]);
        s1_next.gz      = msg_pkg::mag16(s_tdata[160:145]);
        if (steer_ext < lim_neg)
            s1_next.steer = lim_neg[15:0];
        else if (steer_ext > lim_pos)
            s1_next.steer = lim_pos[15:0];
        else
            s1_next.steer = in_steer;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
            s1_reg <= s1_next;
    end

    // stage 2: l1 sum, gyro and tilt limits, tof status
    msg_pkg::stg2_t s2_reg, s2_next;

    logic [msg_pkg::MAG_W-1:0] gyro_lim_ext, tilt_lim_ext;

    assign gyro_lim_ext = {1'b0, gyro_limit_reg};
    assign tilt_lim_ext = {1'b0, tilt_limit_reg};

    always_comb
    begin
        s2_next.left    = s1_reg.left;
        s2_next.right   = s1_reg.right;
        s2_next.steer   = s1_reg.steer;
        s2_next.enable  = s1_reg.enable;
        s2_next.fresh   = s1_reg.fresh;
        s2_next.forward = s1_reg.forward;
        s2_next.tof     = s1_reg.init && s1_reg.tof_all && s1_reg.in_time;
        s2_next.hard    = s1_reg.init && !s2_next.tof && s1_reg.in_time;
        s2_next.gyro_tilt_ok = (s1_reg.gx <= gyro_lim_ext) && (s1_reg.gy <= gyro_lim_ext)
                               && (s1_reg.gz <= gyro_lim_ext)
                               && (s1_reg.ax <= tilt_lim_ext) && (s1_reg.ay <= tilt_lim_ext);
        s2_next.l1      = {2'b00, s1_reg.ax} + {2'b00, s1_reg.ay} + {2'b00, s1_reg.az};
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
            s2_reg <= s2_next;
    end

    // stage 3: shock check, veto, output word
    msg_pkg::stg3_t s3_reg, s3_next;
    logic veto;

    always_comb
    begin
        s3_next.tof     = s2_reg.tof;
        s3_next.hard    = s2_reg.hard;
        s3_next.steer   = s2_reg.steer;
        s3_next.imu     = s2_reg.gyro_tilt_ok && (s2_reg.l1 <= {2'b00, shock_limit_reg});
        s3_next.allowed = s2_reg.fresh && s2_reg.tof && s3_next.imu;
        veto            = !s2_reg.fresh || !s3_next.imu || (s2_reg.forward && !s2_reg.tof);
        s3_next.left    = veto ? 16'sd0 : s2_reg.left;
        s3_next.right   = veto ? 16'sd0 : s2_reg.right;
        s3_next.enable  = s2_reg.enable && !veto;
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
            s3_reg <= s3_next;
    end

    assign m_tvalid = s3_valid_reg;
    assign m_tdata  = {3'b000, s3_reg.hard, s3_reg.allowed, s3_reg.imu, s3_reg.tof,
                       s3_reg.enable, s3_reg.steer, s3_reg.right, s3_reg.left};

endmodule

`default_nettype wire
